@@ design/crcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, codes and the crc-32 byte step for the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_GOOD = 32'h0000_0000;

    // input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam logic CFG_HEADER_VALUE  = 1'b0;
    localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

    localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd100;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_READ = 3'b010,
        ST_PUSH = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic take_item;
        logic emit_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_pass;
        logic out_free;
        logic emit_last;
    } dp_status_t;

    // msb-first crc-32 over one byte, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'h00_0000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ design/crcfr_ram.sv @@
// ----------------------------------------------------------------------------
// crcfr_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module crcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/crcfr_datapath.sv @@
// ----------------------------------------------------------------------------
// crcfr_datapath
// Header match, crc check, payload buffer, tick counter and output register.
// ----------------------------------------------------------------------------
module crcfr_datapath #(
    parameter int HEADER_BYTES  = 2,
    parameter int PAYLOAD_BYTES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    input  crcfr_pkg::ctrl_cmd_t   cmd,
    output crcfr_pkg::dp_status_t  status,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [15:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int FRAME_BODY = PAYLOAD_BYTES + 4;
    localparam int IDX_W      = $clog2(FRAME_BODY);
    localparam int AW         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic [15:0]      header_value_reg,  header_value_next;
    logic [15:0]      timeout_limit_reg, timeout_limit_next;
    logic             in_data_reg,       in_data_next;
    logic [IDX_W-1:0] byte_index_reg,    byte_index_next;
    logic [31:0]      crc_reg,           crc_next;
    logic [15:0]      tick_count_reg,    tick_count_next;
    logic             link_good_reg,     link_good_next;
    logic [AW-1:0]    emit_idx_reg,      emit_idx_next;
    logic             out_valid_reg,     out_valid_next;
    logic             out_kind_reg,      out_kind_next;
    logic [7:0]       out_byte_reg,      out_byte_next;
    logic             out_last_reg,      out_last_next;
    logic             out_link_reg,      out_link_next;

    logic [31:0] crc_step;
    logic [16:0] tick_inc;
    logic [7:0]  want;
    logic        is_byte;
    logic        frame_end;
    logic        timeout_hit;
    logic        ram_we;
    logic [7:0]  ram_rdata;

    assign is_byte   = (s_tuser == crcfr_pkg::OP_BYTE);
    assign crc_step  = crcfr_pkg::crc_byte(crc_reg, s_tdata);
    assign tick_inc  = {1'b0, tick_count_reg} + 17'd1;
    assign timeout_hit = !is_byte && (tick_inc > {1'b0, timeout_limit_reg});
    assign frame_end = in_data_reg && (byte_index_reg == IDX_W'(FRAME_BODY - 1));
    assign want      = (HEADER_BYTES > 1 && byte_index_reg[0]) ?
                       header_value_reg[15:8] : header_value_reg[7:0];
    assign ram_we    = cmd.take_item && is_byte && in_data_reg &&
                       (byte_index_reg < IDX_W'(PAYLOAD_BYTES));

    assign status.frame_pass = is_byte && frame_end && (crc_step == crcfr_pkg::CRC_GOOD);
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.emit_last  = (emit_idx_reg == AW'(PAYLOAD_BYTES - 1));

    crcfr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES),
        .AW    (AW)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (byte_index_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (emit_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        header_value_next  = header_value_reg;
        timeout_limit_next = timeout_limit_reg;
        in_data_next       = in_data_reg;
        byte_index_next    = byte_index_reg;
        crc_next           = crc_reg;
        tick_count_next    = tick_count_reg;
        link_good_next     = link_good_reg;
        emit_idx_next      = emit_idx_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_kind_next      = out_kind_reg;
        out_byte_next      = out_byte_reg;
        out_last_next      = out_last_reg;
        out_link_next      = out_link_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                crcfr_pkg::CFG_HEADER_VALUE:  header_value_next  = cfg_wdata;
                crcfr_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_next = cfg_wdata;
            endcase
        end

        if (cmd.take_item) begin
            emit_idx_next = '0;
            if (!is_byte) begin
                if (timeout_hit) begin
                    tick_count_next = '0;
                    link_good_next  = 1'b0;
                    in_data_next    = 1'b0;
                    byte_index_next = '0;
                    crc_next        = crcfr_pkg::CRC_INIT;
                    out_valid_next  = 1'b1;
                    out_kind_next   = crcfr_pkg::KIND_TIMEOUT;
                    out_byte_next   = 8'h00;
                    out_last_next   = 1'b1;
                    out_link_next   = 1'b0;
                end else begin
                    tick_count_next = tick_inc[15:0];
                end
            end else if (!in_data_reg) begin
                // header hunt, a mismatching byte is not retried as byte 0
                if (want == s_tdata) begin
                    if (byte_index_reg == IDX_W'(HEADER_BYTES - 1)) begin
                        byte_index_next = '0;
                        in_data_next    = 1'b1;
                        crc_next        = crcfr_pkg::CRC_INIT;
                    end else begin
                        byte_index_next = byte_index_reg + IDX_W'(1);
                    end
                end else begin
                    byte_index_next = '0;
                end
            end else begin
                crc_next = crc_step;
                if (frame_end) begin
                    if (status.frame_pass) begin
                        tick_count_next = '0;
                        link_good_next  = 1'b1;
                    end
                    in_data_next    = 1'b0;
                    byte_index_next = '0;
                    crc_next        = crcfr_pkg::CRC_INIT;
                end else begin
                    byte_index_next = byte_index_reg + IDX_W'(1);
                end
            end
        end

        if (cmd.emit_load) begin
            out_valid_next = 1'b1;
            out_kind_next  = crcfr_pkg::KIND_PAYLOAD;
            out_byte_next  = ram_rdata;
            out_last_next  = status.emit_last;
            out_link_next  = 1'b1;
            emit_idx_next  = emit_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_value_reg  <= '0;
            timeout_limit_reg <= crcfr_pkg::TIMEOUT_LIMIT_RESET;
            in_data_reg       <= 1'b0;
            byte_index_reg    <= '0;
            crc_reg           <= crcfr_pkg::CRC_INIT;
            tick_count_reg    <= '0;
            link_good_reg     <= 1'b0;
            emit_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            header_value_reg  <= header_value_next;
            timeout_limit_reg <= timeout_limit_next;
            in_data_reg       <= in_data_next;
            byte_index_reg    <= byte_index_next;
            crc_reg           <= crc_next;
            tick_count_reg    <= tick_count_next;
            link_good_reg     <= link_good_next;
            emit_idx_reg      <= emit_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_link_reg <= out_link_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_link_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ design/crcfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// crcfr_ctrl
// Controller: takes items, then walks the payload buffer after a good frame.
// ----------------------------------------------------------------------------
module crcfr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  crcfr_pkg::dp_status_t  status,
    output crcfr_pkg::ctrl_cmd_t   cmd
);

    crcfr_pkg::ctrl_state_t state_reg, state_next;

    assign s_tready      = (state_reg == crcfr_pkg::ST_RUN) && status.out_free;
    assign cmd.take_item = s_tready && s_tvalid;
    assign cmd.emit_load = (state_reg == crcfr_pkg::ST_PUSH) && status.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crcfr_pkg::ST_RUN: begin
                if (cmd.take_item && status.frame_pass) begin
                    state_next = crcfr_pkg::ST_READ;
                end
            end
            // ram read issued here, data lands for the push state
            crcfr_pkg::ST_READ: begin
                state_next = crcfr_pkg::ST_PUSH;
            end
            crcfr_pkg::ST_PUSH: begin
                if (status.out_free) begin
                    state_next = status.emit_last ? crcfr_pkg::ST_RUN : crcfr_pkg::ST_READ;
                end
            end
            default: state_next = crcfr_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crcfr_pkg::ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/crc32_checked_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// crc32_checked_frame_receiver_unit
// Header-synced frame receiver with crc-32 check and link timeout.
//
//   channel | ports                      | contents (lowest bit first)
//   --------+----------------------------+----------------------------------
//   input   | s_tvalid s_tready          | tuser: operation
//           | s_tdata s_tuser            | tdata: rx_byte
//   result  | m_tvalid m_tready m_tlast  | tuser: kind, tlast: last
//           | m_tdata m_tuser            | tdata: payload_byte, link_ok
//   config  | cfg_we cfg_index cfg_wdata | 0 header_value, 1 timeout_limit
//
// An item (byte or tick) is taken while the controller is in its run state and
// the result register is empty or drained in the same cycle.
// After a frame passes its crc, each payload byte goes through a buffer ram
// read, then the result register; no input is taken until the payload is out.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled result holds the input off until m_tready returns.
// ----------------------------------------------------------------------------
module crc32_checked_frame_receiver_unit #(
    parameter int HEADER_BYTES  = 2,
    parameter int PAYLOAD_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] link_ok
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast
);

    crcfr_pkg::ctrl_cmd_t  cmd;
    crcfr_pkg::dp_status_t status;

    crcfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crcfr_datapath #(
        .HEADER_BYTES  (HEADER_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a passing frame shuts the input while the payload drains
    a_pass_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_item && status.frame_pass |=> !s_tready)
        else $error("input open right after a passing frame");

    a_timeout_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == crcfr_pkg::KIND_TIMEOUT) |->
            m_tlast && !m_tdata[8] && (m_tdata[7:0] == 8'h00))
        else $error("timeout result with wrong fields");

    a_payload_link_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == crcfr_pkg::KIND_PAYLOAD) |-> m_tdata[8])
        else $error("payload beat without link good");

    a_no_load_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take_item && cmd.emit_load))
        else $error("item taken during payload drain");

endmodule

@@ tb/tb_crc32_checked_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// tb_crc32_checked_frame_receiver_unit
// Self-checking bench for the header-synced crc-32 frame receiver. Frames are
// built with a correct or a damaged crc, mixed with ticks, stray bytes and
// cut-off frames, and sent under several header and timeout settings. A
// beat-level model of the receiver predicts every payload and timeout beat,
// and the monitor compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_crc32_checked_frame_receiver_unit;

    localparam int HEADER_BYTES  = 2;
    localparam int PAYLOAD_BYTES = 16;
    localparam int BODY_BYTES    = PAYLOAD_BYTES + 4;
    localparam int SETTLE_CYCLES = 2 * PAYLOAD_BYTES + 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 12;

    // kinds of generated frames
    localparam int FRAME_GOOD    = 0;
    localparam int FRAME_EXTREME = 1;
    localparam int FRAME_BAD     = 2;

    // receiver hold-off sequence
    localparam int HOLD_WAIT   = 0;
    localparam int HOLD_ACTIVE = 1;
    localparam int HOLD_DONE   = 2;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic       link_ok;
    } rx_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = crcfr_pkg::CFG_HEADER_VALUE;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;              // [7:0] rx_byte
    logic        s_tuser   = crcfr_pkg::OP_BYTE; // [0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [7:0] payload_byte, [8] link_ok
    logic        m_tuser;             // [0] kind
    logic        m_tlast;

    crc32_checked_frame_receiver_unit #(
        .HEADER_BYTES (HEADER_BYTES),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // receiver model state and its copy of the registers
    logic [15:0] cfg_header = 16'h0000;
    logic [15:0] cfg_limit  = crcfr_pkg::TIMEOUT_LIMIT_RESET;
    logic        rx_in_data = 1'b0;
    int          rx_index   = 0;
    logic [31:0] rx_crc     = crcfr_pkg::CRC_INIT;
    logic [7:0]  rx_store [PAYLOAD_BYTES];
    int          rx_ticks   = 0;
    logic        rx_link    = 1'b0;

    rx_item_t   beats_to_send [$];
    rx_result_t frame_out_due [$];

    int items_queued   = 0;
    int items_taken    = 0;
    int results_seen   = 0;
    int frames_passed  = 0;
    int timeouts_seen  = 0;
    int mismatch_count = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    int hold_state     = HOLD_WAIT;
    int hold_left      = 0;

    rx_item_t   next_item;
    rx_result_t got_result;
    rx_result_t want_result;

    function automatic logic [31:0] crc32_step(input logic [31:0] crc_in,
                                               input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h00_0000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ crcfr_pkg::CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    function automatic bit quiet_stretch();
        return items_taken >= 150 && items_taken < 250;
    endfunction

    task automatic restart_hunt();
        rx_in_data = 1'b0;
        rx_index   = 0;
        rx_crc     = crcfr_pkg::CRC_INIT;
    endtask

    // advance the receiver model by one accepted input beat
    task automatic advance_receiver(input rx_item_t it);
        rx_result_t r;
        if (it.op == crcfr_pkg::OP_TICK) begin
            if (rx_ticks + 1 > int'(cfg_limit)) begin
                rx_ticks = 0;
                rx_link  = 1'b0;
                restart_hunt();
                r = '{kind: crcfr_pkg::KIND_TIMEOUT, data: 8'h00, last: 1'b1,
                      link_ok: 1'b0};
                frame_out_due.push_back(r);
            end else begin
                rx_ticks = rx_ticks + 1;
            end
        end else if (!rx_in_data) begin
            // a mismatching byte is dropped, not retried as header byte 0
            if (rx_index < HEADER_BYTES && cfg_header[rx_index*8 +: 8] == it.data) begin
                rx_index = rx_index + 1;
                if (rx_index >= HEADER_BYTES) begin
                    rx_index   = 0;
                    rx_in_data = 1'b1;
                    rx_crc     = crcfr_pkg::CRC_INIT;
                end
            end else begin
                rx_index = 0;
            end
        end else begin
            if (rx_index < PAYLOAD_BYTES)
                rx_store[rx_index] = it.data;
            rx_crc   = crc32_step(rx_crc, it.data);
            rx_index = rx_index + 1;
            if (rx_index >= BODY_BYTES) begin
                if (rx_crc == crcfr_pkg::CRC_GOOD) begin
                    rx_ticks = 0;
                    rx_link  = 1'b1;
                    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                        r = '{kind: crcfr_pkg::KIND_PAYLOAD, data: rx_store[k],
                              last: (k == PAYLOAD_BYTES - 1), link_ok: 1'b1};
                        frame_out_due.push_back(r);
                    end
                end
                restart_hunt();
            end
        end
    endtask

    task automatic push_item(input logic op, input logic [7:0] data);
        rx_item_t it;
        it.op   = op;
        it.data = data;
        beats_to_send.push_back(it);
        items_queued++;
    endtask

    // header, payload and the crc register value msb first, so the residue is zero
    task automatic add_frame(input int mode);
        logic [31:0] crc;
        logic [7:0]  body [BODY_BYTES];
        int          pos;
        crc = crcfr_pkg::CRC_INIT;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (mode == FRAME_EXTREME)
                body[k] = k[0] ? 8'hFF : 8'h00;
            else
                body[k] = 8'($urandom_range(0, 255));
            crc = crc32_step(crc, body[k]);
        end
        for (int k = 0; k < 4; k++)
            body[PAYLOAD_BYTES + k] = crc[31 - 8*k -: 8];
        if (mode == FRAME_BAD) begin
            pos = $urandom_range(0, BODY_BYTES - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        push_item(crcfr_pkg::OP_BYTE, cfg_header[7:0]);
        push_item(crcfr_pkg::OP_BYTE, cfg_header[15:8]);
        for (int k = 0; k < BODY_BYTES; k++) begin
            if (mode != FRAME_EXTREME && $urandom_range(0, 39) == 0)
                push_item(crcfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            push_item(crcfr_pkg::OP_BYTE, body[k]);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == crcfr_pkg::CFG_HEADER_VALUE)
            cfg_header = val;
        else
            cfg_limit = val;
        settings_used++;
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || frame_out_due.size() != 0)
            @(posedge aclk);
        // a beat that causes nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int target);
        int start;
        int pick;
        int n;
        start = items_queued;
        while (items_queued - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                add_frame(FRAME_GOOD);
            end else if (pick < 78) begin
                add_frame(FRAME_BAD);
            end else if (pick < 88) begin
                n = $urandom_range(1, 6);
                repeat (n) push_item(crcfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                n = $urandom_range(1, 4);
                repeat (n) push_item(crcfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                // header and a cut-off body; what follows lands in the data phase
                push_item(crcfr_pkg::OP_BYTE, cfg_header[7:0]);
                push_item(crcfr_pkg::OP_BYTE, cfg_header[15:8]);
                n = $urandom_range(1, BODY_BYTES - 1);
                repeat (n) push_item(crcfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
        wait_drained();
    endtask

    task automatic note_mismatch(input string what, input rx_result_t want,
                                 input rx_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%s: expected kind %0d byte %02h last %0d link %0d, ",
                      "got kind %0d byte %02h last %0d link %0d"},
                     what, want.kind, want.data, want.last, want.link_ok,
                     got.kind, got.data, got.last, got.link_ok);
    endtask

    // input driver: predicts on each accepted beat, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_receiver(rx_item_t'{op: s_tuser, data: s_tdata});
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (beats_to_send.size() != 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    next_item = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.op;
                    s_tdata  <= next_item.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver stall once results are flowing
    always @(posedge aclk) begin
        if (aresetn) begin
            case (hold_state)
                HOLD_WAIT: begin
                    if (results_seen >= 40) begin
                        hold_state <= HOLD_ACTIVE;
                        hold_left  <= 400;
                    end
                end
                HOLD_ACTIVE: begin
                    if (hold_left <= 1)
                        hold_state <= HOLD_DONE;
                    else
                        hold_left <= hold_left - 1;
                end
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= hold_state != HOLD_ACTIVE &&
                        (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = '{kind: m_tuser, data: m_tdata[7:0], last: m_tlast,
                           link_ok: m_tdata[8]};
            results_seen++;
            if (frame_out_due.size() == 0) begin
                note_mismatch("unexpected beat", '0, got_result);
            end else begin
                want_result = frame_out_due.pop_front();
                if (want_result.kind == crcfr_pkg::KIND_TIMEOUT)
                    timeouts_seen++;
                else if (want_result.last)
                    frames_passed++;
                if (got_result !== want_result)
                    note_mismatch("result beat", want_result, got_result);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results still due",
                     cycle_count, frame_out_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero header, payload of alternating extremes, one quiet tick
        add_frame(FRAME_EXTREME);
        push_item(crcfr_pkg::OP_TICK, 8'hFF);
        wait_drained();

        // header byte repeated then broken: no sync; zero limit times out at once
        write_reg(crcfr_pkg::CFG_HEADER_VALUE, 16'hAB55);
        write_reg(crcfr_pkg::CFG_TIMEOUT_LIMIT, 16'h0000);
        end_writes();
        push_item(crcfr_pkg::OP_BYTE, 8'h55);
        push_item(crcfr_pkg::OP_BYTE, 8'h55);
        push_item(crcfr_pkg::OP_BYTE, 8'hAB);
        push_item(crcfr_pkg::OP_TICK, 8'h00);
        wait_drained();
        run_random(60);

        write_reg(crcfr_pkg::CFG_HEADER_VALUE, 16'hFFFF);
        write_reg(crcfr_pkg::CFG_TIMEOUT_LIMIT, 16'hFFFF);
        end_writes();
        run_random(120);

        write_reg(crcfr_pkg::CFG_HEADER_VALUE, 16'h0000);
        write_reg(crcfr_pkg::CFG_TIMEOUT_LIMIT, 16'd3);
        end_writes();
        run_random(80);

        write_reg(crcfr_pkg::CFG_HEADER_VALUE, 16'($urandom_range(0, 65535)));
        write_reg(crcfr_pkg::CFG_TIMEOUT_LIMIT, 16'($urandom_range(5, 40)));
        end_writes();
        run_random(120);

        $display("sent %0d input beats under %0d register writes, checked %0d result beats",
                 items_taken, settings_used, results_seen);
        $display("%0d frames passed crc, %0d link timeouts, %0d mismatches",
                 frames_passed, timeouts_seen, mismatch_count);
        if (mismatch_count == 0 && frame_out_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
